### hdl/rhht_pkg.sv
// Shared types and constants for the rectangle hotspot hit test block.
package rhht_pkg;

  localparam int ID_W    = 16;
  localparam int COORD_W = 16;
  localparam int SLOT_W  = 5;

  // Command codes carried by each input word.
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_HIDE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TEST  = 2'd3
  } cmd_t;

  // Inclusive rectangle corners.
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
  } rect_t;

  // One stored table entry, visible mark kept apart.
  typedef struct packed {
    logic [ID_W-1:0] id;
    rect_t           rect;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } dp_sts_t;

endpackage

### hdl/rhht_ctrl.sv
// Controller state machine for the rectangle hotspot hit test block.
module rhht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  output logic              in_stall,
  input  rhht_pkg::dp_sts_t sts,
  output rhht_pkg::dp_cmd_t cmd
);
  import rhht_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   accept;

  assign in_stall = in_stall_r;
  assign accept   = (state_r == S_IDLE) && in_valid && !in_stall_r;

  // Next state and stall decision.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_command))
            CMD_ADD, CMD_CLEAR: state_nxt = S_EXEC;
            CMD_HIDE, CMD_TEST: state_nxt = S_SCAN;
            default:            state_nxt = S_EXEC;
          endcase
        end
      end
      S_EXEC: state_nxt = S_FINISH;
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    in_stall_nxt = (state_nxt != S_IDLE);
  end

  // Commands to the datapath, decoded from the present state.
  always_comb begin
    cmd.capture  = accept;
    cmd.exec     = (state_r == S_EXEC);
    cmd.scan     = (state_r == S_SCAN);
    cmd.load_out = (state_r == S_FINISH) && !sts.out_busy;
  end

  // State and registered stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

endmodule

### hdl/rhht_dp.sv
// Datapath for the rectangle hotspot hit test block: table memory, scan and result register.
module rhht_dp #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rhht_pkg::dp_cmd_t                    cmd,
  output rhht_pkg::dp_sts_t                    sts,
  input  logic [1:0]                           in_command,
  input  logic [rhht_pkg::ID_W-1:0]            in_entry_id,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_left,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_top,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_right,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_bottom,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_point_y,
  input  logic [rhht_pkg::ID_W-1:0]            in_floor_id,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_status,
  output logic                                 out_hit,
  output logic [rhht_pkg::ID_W-1:0]            out_winner_id,
  output logic [rhht_pkg::SLOT_W-1:0]          out_winner_slot
);
  import rhht_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = IDX_W + SLOT_W;

  // Table storage.
  entry_t ent_mem [TABLE_DEPTH];
  logic   vis_mem [TABLE_DEPTH];

  // Captured word.
  cmd_t                      op_r;
  logic [ID_W-1:0]           id_r;
  rect_t                     rect_r;
  logic signed [COORD_W-1:0] px_r;
  logic signed [COORD_W-1:0] py_r;

  // Control state.
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             rd_valid_r, rd_valid_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Scan state and read data.
  logic [IDX_W-1:0] rd_slot_r;
  entry_t           rd_entry_r;
  logic             rd_vis_r;
  logic [ID_W-1:0]  best_r;
  logic             hit_r;
  logic [IDX_W-1:0] slot_r;
  logic             status_r;

  // Result register.
  logic              out_status_r;
  logic              out_hit_r;
  logic [ID_W-1:0]   out_winner_id_r;
  logic [SLOT_W-1:0] out_winner_slot_r;

  logic             full;
  logic             issue;
  logic [CNT_W-1:0] idx_dec;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             contains;
  logic             test_hit;
  logic             hide_hit;
  logic [EXT_W-1:0] slot_ext;

  assign full    = (fill_r == CNT_W'(TABLE_DEPTH));
  assign wr_addr = fill_r[IDX_W-1:0];
  assign idx_dec = idx_r - CNT_W'(1);
  assign rd_addr = idx_dec[IDX_W-1:0];
  assign issue   = cmd.scan && (idx_r != '0);

  // Candidate checks on the entry read in the previous cycle.
  assign contains = (px_r >= rd_entry_r.rect.left) && (px_r <= rd_entry_r.rect.right) &&
                    (py_r >= rd_entry_r.rect.top)  && (py_r <= rd_entry_r.rect.bottom);
  assign test_hit = cmd.scan && rd_valid_r && (op_r == CMD_TEST) && rd_vis_r &&
                    (rd_entry_r.id > best_r) && contains;
  assign hide_hit = cmd.scan && rd_valid_r && (op_r == CMD_HIDE) && (rd_entry_r.id == id_r);

  assign sts.scan_done = hide_hit || ((idx_r == '0) && !rd_valid_r);
  assign sts.out_busy  = out_valid_r && out_stall;

  // Next values of the control registers.
  always_comb begin
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    rd_valid_nxt  = rd_valid_r;
    out_valid_nxt = out_valid_r;
    if (cmd.capture) begin
      idx_nxt      = fill_r;
      rd_valid_nxt = 1'b0;
    end else if (cmd.scan) begin
      rd_valid_nxt = issue;
      if (issue) idx_nxt = idx_dec;
    end
    if (cmd.exec) begin
      if (op_r == CMD_CLEAR) begin
        fill_nxt = '0;
      end else if (!full) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      idx_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Captured word, scan bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= cmd_t'(in_command);
      id_r        <= in_entry_id;
      rect_r      <= '{left: in_left, top: in_top, right: in_right, bottom: in_bottom};
      px_r        <= in_point_x;
      py_r        <= in_point_y;
      best_r      <= in_floor_id;
      hit_r       <= 1'b0;
      slot_r      <= '0;
      status_r    <= 1'b0;
    end else begin
      if (cmd.exec && (op_r == CMD_ADD) && full) status_r <= 1'b1;
      if (test_hit) begin
        best_r <= rd_entry_r.id;
        hit_r  <= 1'b1;
        slot_r <= rd_slot_r;
      end
    end
    if (issue) rd_slot_r <= rd_addr;
    if (cmd.load_out) begin
      out_status_r      <= status_r;
      out_hit_r         <= hit_r;
      out_winner_id_r   <= (op_r == CMD_TEST) ? best_r : '0;
      out_winner_slot_r <= slot_ext[SLOT_W-1:0];
    end
  end

  // Slot number reported modulo the width of the result field.
  assign slot_ext = EXT_W'(slot_r);

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == CMD_ADD) && !full) begin
      ent_mem[wr_addr] <= '{id: id_r, rect: rect_r};
      vis_mem[wr_addr] <= 1'b1;
    end else if (hide_hit) begin
      vis_mem[rd_slot_r] <= 1'b0;
    end
    if (issue) begin
      rd_entry_r <= ent_mem[rd_addr];
      rd_vis_r   <= vis_mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hit         = out_hit_r;
  assign out_winner_id   = out_winner_id_r;
  assign out_winner_slot = out_winner_slot_r;

endmodule

### hdl/rectangle_hotspot_hit_test_core.sv
// Top level of the rectangle hotspot hit test block.
// Each word is accepted only while the block is idle; in_stall stays high until
// the word's result has been loaded into the result register. A hit test or a
// hide scans the table newest entry first (a hide may end early), reading one
// table entry per cycle through one memory port. Reset empties the table, sends
// the controller back to idle and clears out_valid; stored entries are kept.
module rectangle_hotspot_hit_test_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_command,
  input  logic [rhht_pkg::ID_W-1:0]            in_entry_id,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_left,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_top,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_right,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_bottom,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [rhht_pkg::COORD_W-1:0]  in_point_y,
  input  logic [rhht_pkg::ID_W-1:0]            in_floor_id,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_status,
  output logic                                 out_hit,
  output logic [rhht_pkg::ID_W-1:0]            out_winner_id,
  output logic [rhht_pkg::SLOT_W-1:0]          out_winner_slot
);
  import rhht_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing of each word.
  rhht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Table, scan and result register.
  rhht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_command),
    .in_entry_id     (in_entry_id),
    .in_left         (in_left),
    .in_top          (in_top),
    .in_right        (in_right),
    .in_bottom       (in_bottom),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_floor_id     (in_floor_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_winner_id   (out_winner_id),
    .out_winner_slot (out_winner_slot)
  );

endmodule

### sim/rectangle_hotspot_hit_test_core_tb.sv
// Self-checking testbench for the rectangle hotspot hit test core.
module rectangle_hotspot_hit_test_core_tb;
  import rhht_pkg::*;

  localparam int DEPTH = 32;
  // Once this few words are left to send, neither side adds random idle bursts any more.
  localparam int TAIL = 150;

  // One input word as the sender offers it; drain holds it back until all is answered.
  typedef struct {
    cmd_t               cmd;
    logic [15:0]        entry_id;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [15:0]        floor_id;
    bit                 drain;
  } hs_word_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [15:0] win_id;
    logic [4:0]  win_slot;
  } hs_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = '0;
  logic [15:0]        in_entry_id = '0;
  logic signed [15:0] in_left = '0;
  logic signed [15:0] in_top = '0;
  logic signed [15:0] in_right = '0;
  logic signed [15:0] in_bottom = '0;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic [15:0]        in_floor_id = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_status;
  logic               out_hit;
  logic [15:0]        out_winner_id;
  logic [4:0]         out_winner_slot;

  rectangle_hotspot_hit_test_core #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_entry_id     (in_entry_id),
    .in_left         (in_left),
    .in_top          (in_top),
    .in_right        (in_right),
    .in_bottom       (in_bottom),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_floor_id     (in_floor_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_winner_id   (out_winner_id),
    .out_winner_slot (out_winner_slot)
  );

  hs_word_t   pending_words[$];
  hs_result_t due_results[$];
  hs_word_t   on_port;
  hs_result_t got, want;
  int         n_total = 0;
  int         n_accepted = 0;
  int         n_fail = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  bit         held_off = 1'b0;
  bit         want_drain = 1'b0;

  // Hotspot table as the block should hold it.
  logic [15:0]        tab_id     [DEPTH];
  logic signed [15:0] tab_left   [DEPTH];
  logic signed [15:0] tab_top    [DEPTH];
  logic signed [15:0] tab_right  [DEPTH];
  logic signed [15:0] tab_bottom [DEPTH];
  bit                 tab_vis    [DEPTH];
  int                 tab_fill = 0;

  // Region and id pool shared by the words of one random sequence.
  logic signed [15:0] area_x, area_y;
  int                 area_span;
  logic [15:0]        id_pool;

  // Updates the table for one command and returns the word the block must answer with.
  function automatic hs_result_t apply_command(hs_word_t w);
    hs_result_t r;
    logic [15:0] best;
    bit hidden;
    int k;
    r = '0;
    hidden = 1'b0;
    case (w.cmd)
      CMD_ADD: begin
        if (tab_fill >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          tab_id[tab_fill]     = w.entry_id;
          tab_left[tab_fill]   = w.left;
          tab_top[tab_fill]    = w.top;
          tab_right[tab_fill]  = w.right;
          tab_bottom[tab_fill] = w.bottom;
          tab_vis[tab_fill]    = 1'b1;
          tab_fill++;
        end
      end
      CMD_HIDE: begin
        // Only the newest entry with the id is touched, visible or not.
        for (k = tab_fill - 1; k >= 0; k--) begin
          if (!hidden && tab_id[k] == w.entry_id) begin
            tab_vis[k] = 1'b0;
            hidden = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        tab_fill = 0;
      end
      CMD_TEST: begin
        // Scan newest first; a later match needs a strictly higher id, so ties stay newest.
        best = w.floor_id;
        r.win_id = best;
        for (k = tab_fill - 1; k >= 0; k--) begin
          if (tab_vis[k] && tab_id[k] > best &&
              w.point_x >= tab_left[k] && w.point_x <= tab_right[k] &&
              w.point_y >= tab_top[k] && w.point_y <= tab_bottom[k]) begin
            best = tab_id[k];
            r.hit = 1'b1;
            r.win_id = best;
            r.win_slot = k[4:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic push_word(hs_word_t w);
    w.drain = want_drain || ($urandom_range(0, 199) == 0);
    want_drain = 1'b0;
    pending_words.push_back(w);
    n_total++;
  endtask

  task automatic put(input cmd_t c, input logic [15:0] id,
                     input logic signed [15:0] l, t, r, b, px, py,
                     input logic [15:0] fl);
    hs_word_t w;
    w = '{c, id, l, t, r, b, px, py, fl, 1'b0};
    push_word(w);
  endtask

  // Every field random, so that fields a command ignores see all values too.
  function automatic hs_word_t junk_word();
    hs_word_t w;
    w.cmd      = cmd_t'($urandom_range(0, 3));
    w.entry_id = 16'($urandom);
    w.left     = 16'($urandom);
    w.top      = 16'($urandom);
    w.right    = 16'($urandom);
    w.bottom   = 16'($urandom);
    w.point_x  = 16'($urandom);
    w.point_y  = 16'($urandom);
    w.floor_id = 16'($urandom);
    w.drain    = 1'b0;
    return w;
  endfunction

  function automatic logic [15:0] pool_id();
    return id_pool + 16'($urandom_range(0, 7));
  endfunction

  function automatic hs_word_t add_word();
    hs_word_t w;
    w = junk_word();
    w.cmd = CMD_ADD;
    if ($urandom_range(0, 3) != 0) w.entry_id = pool_id();
    if ($urandom_range(0, 7) != 0) begin
      // Small rectangles in the region; now and then right of left or below top is off by one or two.
      w.left   = area_x + 16'($urandom_range(0, area_span));
      w.right  = w.left + 16'($urandom_range(0, area_span)) - 16'sd2;
      w.top    = area_y + 16'($urandom_range(0, area_span));
      w.bottom = w.top + 16'($urandom_range(0, area_span)) - 16'sd2;
    end
    return w;
  endfunction

  function automatic hs_word_t test_word();
    hs_word_t w;
    w = junk_word();
    w.cmd = CMD_TEST;
    if ($urandom_range(0, 7) != 0) begin
      w.point_x = area_x + 16'($urandom_range(0, area_span + 4)) - 16'sd2;
      w.point_y = area_y + 16'($urandom_range(0, area_span + 4)) - 16'sd2;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: w.floor_id = 16'h0000;
      5, 6, 7:       w.floor_id = pool_id();
      default:       w.floor_id = 16'($urandom);
    endcase
    return w;
  endfunction

  function automatic hs_word_t hide_word();
    hs_word_t w;
    w = junk_word();
    w.cmd = CMD_HIDE;
    if ($urandom_range(0, 4) != 0) w.entry_id = pool_id();
    return w;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus, reset and the end of the run.
  initial begin
    hs_word_t w;
    int n_add;
    int n_ops;
    int pick;

    // Directed words: empty table, plane extremes, inverted rectangles, ties, hides, clear.
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 0, 0, 16'h0000);
    put(CMD_ADD, 16'hFFFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 0, 0, 16'h0000);
    put(CMD_ADD, 16'h0001, 5, 5, 5, 5, 0, 0, 16'h0000);
    put(CMD_ADD, 16'h8000, 10, 0, -10, 0, 0, 0, 16'h0000);
    put(CMD_ADD, 16'h7000, 0, 10, 0, -10, 0, 0, 16'h0000);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 16'sh8000, 16'sh8000, 16'h0000);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 5, 5, 16'hFFFE);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 0, 0, 16'h7FFF);
    put(CMD_ADD, 16'hFFFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 0, 0, 16'h0000);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 5, 5, 16'h0000);
    put(CMD_HIDE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 16'h0000);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 5, 5, 16'h0000);
    put(CMD_HIDE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 16'h0000);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 0, 0, 16'h0000);
    put(CMD_HIDE, 16'h1234, 0, 0, 0, 0, 0, 0, 16'h0000);
    put(CMD_HIDE, 16'h0001, 0, 0, 0, 0, 0, 0, 16'h0000);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 5, 5, 16'h0000);
    put(CMD_CLEAR, 16'h0000, 0, 0, 0, 0, 0, 0, 16'h0000);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 5, 5, 16'h00AB);
    put(CMD_ADD, 16'h0000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 0, 0, 16'h0000);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 0, 0, 16'h0000);
    put(CMD_ADD, 16'h0002, -1, -1, 1, 1, 0, 0, 16'h0000);
    put(CMD_TEST, 16'h0000, 0, 0, 0, 0, 1, -1, 16'h0000);

    // Random sequences: mostly a clear, a run of adds, then mainly tests and hides in one region.
    want_drain = 1'b1;
    while (n_total < 1524) begin
      case ($urandom_range(0, 7))
        0:       area_x = 16'sh8000;
        1:       area_x = 16'sh7FC0;
        default: area_x = 16'($urandom);
      endcase
      area_y = ($urandom_range(0, 7) == 0) ? 16'sh8000 : 16'($urandom);
      area_span = $urandom_range(0, 60);
      id_pool = 16'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        w = junk_word();
        w.cmd = CMD_CLEAR;
        push_word(w);
      end
      // Now and then enough adds to fill the table and have some refused.
      n_add = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 12);
      repeat (n_add) push_word(add_word());
      n_ops = $urandom_range(4, 20);
      repeat (n_ops) begin
        pick = $urandom_range(0, 19);
        if (pick <= 10) begin
          push_word(test_word());
        end else if (pick <= 14) begin
          push_word(hide_word());
        end else if (pick <= 17) begin
          push_word(add_word());
        end else if (pick == 18) begin
          w = junk_word();
          w.cmd = CMD_CLEAR;
          push_word(w);
        end else begin
          push_word(junk_word());
        end
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Sender: offers the queued words, with random idle bursts and a hold before drain words.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_command(on_port));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() == 0 ||
                     (pending_words[0].drain && due_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (pending_words.size() > TAIL && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else begin
          on_port = pending_words.pop_front();
          in_command  <= on_port.cmd;
          in_entry_id <= on_port.entry_id;
          in_left     <= on_port.left;
          in_top      <= on_port.top;
          in_right    <= on_port.right;
          in_bottom   <= on_port.bottom;
          in_point_x  <= on_port.point_x;
          in_point_y  <= on_port.point_y;
          in_floor_id <= on_port.floor_id;
          in_valid    <= 1'b1;
        end
      end
    end
  end

  // Receiver stall: one long hold-off so the block backs up, then random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!held_off && n_accepted >= 300) begin
      held_off = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (pending_words.size() > TAIL && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Checker: each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_hit, out_winner_id, out_winner_slot};
      if (due_results.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) begin
          $display("unexpected result word: status %0d hit %0d id %h slot %0d",
                   got.status, got.hit, got.win_id, got.win_slot);
        end
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("mismatch: expected status %0d hit %0d id %h slot %0d, got status %0d hit %0d id %h slot %0d",
                     want.status, want.hit, want.win_id, want.win_slot,
                     got.status, got.hit, got.win_id, got.win_slot);
          end
        end
      end
    end
  end

endmodule

### sim.f
hdl/rhht_pkg.sv
hdl/rhht_ctrl.sv
hdl/rhht_dp.sv
hdl/rectangle_hotspot_hit_test_core.sv
sim/rectangle_hotspot_hit_test_core_tb.sv
